[rtl/core/plt_pkg.sv]
// ----------------------------------------------------------------------------
// plt_pkg
// Shared codes, types and reset values of the peer liveness table.
// ----------------------------------------------------------------------------
package plt_pkg;

  // command codes (input tuser[2:0])
  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_REMOVE  = 3'd1;
  localparam logic [2:0] CMD_CLEAR   = 3'd2;
  localparam logic [2:0] CMD_RECEIVE = 3'd3;
  localparam logic [2:0] CMD_SENT    = 3'd4;
  localparam logic [2:0] CMD_TICK    = 3'd5;
  localparam logic [2:0] CMD_QUERY   = 3'd6;

  // event codes (output tuser)
  localparam logic [3:0] EV_ACK       = 4'd0;
  localparam logic [3:0] EV_ADDED     = 4'd1;
  localparam logic [3:0] EV_ADD_REJ   = 4'd2;
  localparam logic [3:0] EV_REMOVED   = 4'd3;
  localparam logic [3:0] EV_REM_MISS  = 4'd4;
  localparam logic [3:0] EV_CONNECTED = 4'd5;
  localparam logic [3:0] EV_HB_RX     = 4'd6;
  localparam logic [3:0] EV_DATA_RX   = 4'd7;
  localparam logic [3:0] EV_BAD_PKT   = 4'd8;
  localparam logic [3:0] EV_HB_DUE    = 4'd9;
  localparam logic [3:0] EV_TIMED_OUT = 4'd10;
  localparam logic [3:0] EV_TICK_DONE = 4'd11;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_PEERS = 2'd0;
  localparam logic [1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_HB_EN     = 2'd2;
  localparam logic [1:0] REG_HB_INT    = 2'd3;

  localparam logic [4:0]  MAX_PEERS_RST = 5'd5;
  localparam logic [31:0] TIMEOUT_RST   = 32'd2000;
  localparam logic [31:0] HB_INT_RST    = 32'd500;

  localparam int unsigned MAC_W = 48;
  localparam int unsigned OUT_TDATA_W = 120;
  localparam int unsigned IN_TDATA_W  = 80;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC
  } idx_op_e;

  typedef enum logic [3:0] {
    ENT_NONE,
    ENT_APPEND,
    ENT_RX_UPD,
    ENT_TX_INC,
    ENT_SHIFT,
    ENT_DROP,
    ENT_CLEAR,
    ENT_SWEEP,
    ENT_HB_START,
    ENT_HB_SKIP
  } ent_op_e;

  typedef enum logic [1:0] {
    MAC_IN,
    MAC_ENTRY,
    MAC_ZERO
  } mac_sel_e;

  typedef struct packed {
    logic     in_ld;
    idx_op_e  idx_op;
    ent_op_e  ent_op;
    logic     pend_wr;
    logic [3:0] pend_ev;
    logic     pend_ok;
    mac_sel_e pend_mac;
    logic     pend_query;
    logic     out_ld;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       parse_ok;
    logic       is_hb;
    logic       at_end;
    logic       at_last;
    logic       match;
    logic       ent_conn;
    logic       full;
    logic       tmo;
    logic       hb_due;
    logic       pend_v;
    logic       out_busy;
  } dp_sts_t;

  typedef struct packed {
    logic [31:0] tx;
    logic [31:0] rx;
    logic        any;
    logic        pc;
    logic [47:0] mac;
    logic        ok;
    logic [3:0]  ev;
  } res_t;

endpackage

[rtl/core/plt_dp.sv]
// ----------------------------------------------------------------------------
// plt_dp
// Datapath: entry registers, scan counter, config, pending and output beat.
// ----------------------------------------------------------------------------
module plt_dp #(
  parameter int unsigned TABLE_SIZE = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  plt_pkg::dp_cmd_t          cmd_i,
  output plt_pkg::dp_sts_t          sts_o,
  input  logic [plt_pkg::IN_TDATA_W-1:0] in_tdata_i,
  input  logic [4:0]                in_tuser_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [31:0]               cfg_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output plt_pkg::res_t             out_res_o,
  output logic                      out_last_o
);
  import plt_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_SIZE + 1);
  localparam int unsigned IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  logic [47:0] mac_q [TABLE_SIZE];
  logic [31:0] ls_q  [TABLE_SIZE];
  logic [31:0] rx_q  [TABLE_SIZE];
  logic [31:0] tx_q  [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] conn_q, conn_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d, nxt;
  logic [IW-1:0] ri, ni;
  logic [31:0] lhb_q, lhb_d;
  logic        hb_q, hb_d;

  logic [2:0]  icmd_q;
  logic [47:0] imac_q;
  logic [31:0] inow_q;
  logic        ipok_q, ihb_q;

  logic [4:0]  maxp_q;
  logic [31:0] tmo_q, hbint_q;
  logic        hben_q;

  res_t pend_q, pend_d;
  logic pend_v_q, pend_v_d;
  res_t out_q;
  logic out_v_q, out_v_d, out_last_q;

  logic [31:0] lim;
  logic        tmo_hit;

  assign nxt = idx_q + CW'(1);
  assign ri  = idx_q[IW-1:0];
  assign ni  = nxt[IW-1:0];

  always_comb begin
    if (maxp_q == 5'd0) begin
      lim = 32'd1;
    end else if (32'(maxp_q) > TABLE_SIZE) begin
      lim = TABLE_SIZE;
    end else begin
      lim = 32'(maxp_q);
    end
  end

  assign tmo_hit = (idx_q != cnt_q) && conn_q[ri] && (ls_q[ri] != 32'd0)
                   && ((inow_q - ls_q[ri]) > tmo_q);

  always_comb begin
    sts_o.cmd      = icmd_q;
    sts_o.parse_ok = ipok_q;
    sts_o.is_hb    = ihb_q;
    sts_o.at_end   = (idx_q == cnt_q);
    sts_o.at_last  = (nxt == cnt_q);
    sts_o.match    = (mac_q[ri] == imac_q);
    sts_o.ent_conn = conn_q[ri];
    sts_o.full     = (32'(cnt_q) >= lim);
    sts_o.tmo      = tmo_hit;
    sts_o.hb_due   = (|conn_q) && hben_q && ((inow_q - lhb_q) >= hbint_q);
    sts_o.pend_v   = pend_v_q;
    sts_o.out_busy = out_v_q;
  end

  // control state of the table
  always_comb begin
    conn_d = conn_q;
    cnt_d  = cnt_q;
    lhb_d  = lhb_q;
    hb_d   = hb_q;
    case (cmd_i.ent_op)
      ENT_APPEND: begin
        conn_d[ri] = 1'b0;
        cnt_d      = cnt_q + CW'(1);
      end
      ENT_RX_UPD:   conn_d[ri] = 1'b1;
      ENT_SHIFT:    conn_d[ri] = conn_q[ni];
      ENT_DROP: begin
        conn_d[ri] = 1'b0;
        cnt_d      = cnt_q - CW'(1);
      end
      ENT_CLEAR: begin
        conn_d = '0;
        cnt_d  = '0;
      end
      ENT_SWEEP: begin
        if (tmo_hit) begin
          conn_d[ri] = 1'b0;
        end
      end
      ENT_HB_START: begin
        lhb_d = inow_q;
        hb_d  = 1'b1;
      end
      ENT_HB_SKIP:  hb_d = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    case (cmd_i.idx_op)
      IDX_CLR: idx_d = '0;
      IDX_INC: idx_d = nxt;
      default: idx_d = idx_q;
    endcase
  end

  always_comb begin
    pend_d     = pend_q;
    pend_d.ev  = cmd_i.pend_ev;
    pend_d.ok  = cmd_i.pend_ok;
    case (cmd_i.pend_mac)
      MAC_IN:    pend_d.mac = imac_q;
      MAC_ENTRY: pend_d.mac = mac_q[ri];
      default:   pend_d.mac = '0;
    endcase
    pend_d.any = |conn_d;
    if (cmd_i.pend_query) begin
      pend_d.pc = conn_q[ri];
      pend_d.rx = rx_q[ri];
      pend_d.tx = tx_q[ri];
    end else begin
      pend_d.pc = 1'b0;
      pend_d.rx = '0;
      pend_d.tx = '0;
    end
  end

  assign pend_v_d = cmd_i.pend_wr | (pend_v_q & ~cmd_i.out_ld);
  assign out_v_d  = cmd_i.out_ld | (out_v_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q   <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      lhb_q    <= '0;
      hb_q     <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      maxp_q   <= MAX_PEERS_RST;
      tmo_q    <= TIMEOUT_RST;
      hben_q   <= 1'b0;
      hbint_q  <= HB_INT_RST;
    end else begin
      conn_q   <= conn_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      lhb_q    <= lhb_d;
      hb_q     <= hb_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MAX_PEERS: maxp_q  <= cfg_data_i[4:0];
          REG_TIMEOUT:   tmo_q   <= cfg_data_i;
          REG_HB_EN:     hben_q  <= cfg_data_i[0];
          REG_HB_INT:    hbint_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload: entries, latched input, pending and output beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_ld) begin
      imac_q <= in_tdata_i[47:0];
      inow_q <= in_tdata_i[79:48];
      icmd_q <= in_tuser_i[2:0];
      ipok_q <= in_tuser_i[3];
      ihb_q  <= in_tuser_i[4];
    end
    case (cmd_i.ent_op)
      ENT_APPEND: begin
        mac_q[ri] <= imac_q;
        ls_q[ri]  <= '0;
        rx_q[ri]  <= '0;
        tx_q[ri]  <= '0;
      end
      ENT_RX_UPD: begin
        ls_q[ri] <= inow_q;
        rx_q[ri] <= rx_q[ri] + 32'd1;
      end
      ENT_TX_INC: tx_q[ri] <= tx_q[ri] + 32'd1;
      ENT_SHIFT: begin
        mac_q[ri] <= mac_q[ni];
        ls_q[ri]  <= ls_q[ni];
        rx_q[ri]  <= rx_q[ni];
        tx_q[ri]  <= tx_q[ni];
      end
      ENT_SWEEP:  tx_q[ri] <= tx_q[ri] + 32'(hb_q);
      default: ;
    endcase
    if (cmd_i.pend_wr) begin
      pend_q <= pend_d;
    end
    if (cmd_i.out_ld) begin
      out_q      <= pend_q;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

[rtl/core/plt_ctrl.sv]
// ----------------------------------------------------------------------------
// plt_ctrl
// Controller: search, command dispatch, removal shift, tick sweep, beat flush.
// ----------------------------------------------------------------------------
module plt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        in_cmd_i,
  input  plt_pkg::dp_sts_t  sts_i,
  output plt_pkg::dp_cmd_t  cmd_o
);
  import plt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EXEC,
    ST_EXEC2,
    ST_SHIFT,
    ST_TICK_HB,
    ST_SWEEP,
    ST_TICK_END,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   found_q, found_d, more_q, more_d;
  logic [3:0] rx_ev;

  assign in_ready_o = (state_q == ST_IDLE);
  assign rx_ev = sts_i.is_hb ? EV_HB_RX : EV_DATA_RX;

  always_comb begin
    state_d = state_q;
    found_d = found_q;
    more_d  = more_q;
    cmd_o.in_ld      = 1'b0;
    cmd_o.idx_op     = IDX_HOLD;
    cmd_o.ent_op     = ENT_NONE;
    cmd_o.pend_wr    = 1'b0;
    cmd_o.pend_ev    = EV_ACK;
    cmd_o.pend_ok    = 1'b0;
    cmd_o.pend_mac   = MAC_IN;
    cmd_o.pend_query = 1'b0;
    cmd_o.out_ld     = 1'b0;
    cmd_o.out_last   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_ld  = 1'b1;
          cmd_o.idx_op = IDX_CLR;
          more_d       = 1'b0;
          state_d      = (in_cmd_i == CMD_TICK) ? ST_TICK_HB : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts_i.at_end) begin
          found_d = 1'b0;
          state_d = ST_EXEC;
        end else if (sts_i.match) begin
          found_d = 1'b1;
          state_d = ST_EXEC;
        end else begin
          cmd_o.idx_op = IDX_INC;
        end
      end
      ST_EXEC: begin
        cmd_o.pend_wr = 1'b1;
        state_d       = ST_FLUSH;
        case (sts_i.cmd)
          CMD_ADD: begin
            if (found_q) begin
              cmd_o.pend_ev = EV_ADDED;
              cmd_o.pend_ok = 1'b1;
            end else if (sts_i.full) begin
              cmd_o.pend_ev = EV_ADD_REJ;
            end else begin
              cmd_o.ent_op  = ENT_APPEND;
              cmd_o.pend_ev = EV_ADDED;
              cmd_o.pend_ok = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (found_q) begin
              cmd_o.pend_wr = 1'b0;
              state_d       = ST_SHIFT;
            end else begin
              cmd_o.pend_ev = EV_REM_MISS;
            end
          end
          CMD_CLEAR: begin
            cmd_o.ent_op   = ENT_CLEAR;
            cmd_o.pend_ok  = 1'b1;
            cmd_o.pend_mac = MAC_ZERO;
          end
          CMD_RECEIVE: begin
            if (!sts_i.parse_ok) begin
              cmd_o.pend_ev = EV_BAD_PKT;
            end else if (found_q) begin
              cmd_o.ent_op  = ENT_RX_UPD;
              cmd_o.pend_ok = 1'b1;
              if (!sts_i.ent_conn) begin
                cmd_o.pend_ev = EV_CONNECTED;
                more_d        = 1'b1;
              end else begin
                cmd_o.pend_ev = rx_ev;
              end
            end else begin
              cmd_o.pend_ev = rx_ev;
            end
          end
          CMD_SENT: begin
            if (found_q) begin
              cmd_o.ent_op = ENT_TX_INC;
            end
            cmd_o.pend_ok = found_q;
          end
          CMD_QUERY: begin
            cmd_o.pend_ok    = found_q;
            cmd_o.pend_query = found_q;
          end
          default: ;
        endcase
      end
      ST_EXEC2: begin
        cmd_o.pend_wr = 1'b1;
        cmd_o.pend_ev = rx_ev;
        cmd_o.pend_ok = 1'b1;
        more_d        = 1'b0;
        state_d       = ST_FLUSH;
      end
      ST_SHIFT: begin
        if (sts_i.at_last) begin
          cmd_o.ent_op  = ENT_DROP;
          cmd_o.pend_wr = 1'b1;
          cmd_o.pend_ev = EV_REMOVED;
          cmd_o.pend_ok = 1'b1;
          state_d       = ST_FLUSH;
        end else begin
          cmd_o.ent_op = ENT_SHIFT;
          cmd_o.idx_op = IDX_INC;
        end
      end
      ST_TICK_HB: begin
        if (sts_i.hb_due) begin
          cmd_o.ent_op   = ENT_HB_START;
          cmd_o.pend_wr  = 1'b1;
          cmd_o.pend_ev  = EV_HB_DUE;
          cmd_o.pend_ok  = 1'b1;
          cmd_o.pend_mac = MAC_ZERO;
        end else begin
          cmd_o.ent_op = ENT_HB_SKIP;
        end
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        // the previous result goes out only once the next one is known,
        // so that the final one can carry tlast
        if (sts_i.at_end) begin
          state_d = ST_TICK_END;
        end else if (!(sts_i.tmo && sts_i.pend_v && sts_i.out_busy)) begin
          cmd_o.ent_op = ENT_SWEEP;
          cmd_o.idx_op = IDX_INC;
          if (sts_i.tmo) begin
            cmd_o.pend_wr  = 1'b1;
            cmd_o.pend_ev  = EV_TIMED_OUT;
            cmd_o.pend_ok  = 1'b1;
            cmd_o.pend_mac = MAC_ENTRY;
            cmd_o.out_ld   = sts_i.pend_v;
          end
        end
      end
      ST_TICK_END: begin
        if (!sts_i.pend_v) begin
          cmd_o.pend_wr  = 1'b1;
          cmd_o.pend_ev  = EV_TICK_DONE;
          cmd_o.pend_ok  = 1'b1;
          cmd_o.pend_mac = MAC_ZERO;
        end
        state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_last = !more_q;
          state_d        = more_q ? ST_EXEC2 : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      found_q <= 1'b0;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      more_q  <= more_d;
    end
  end

endmodule

[rtl/core/peer_liveness_table_top.sv]
// ----------------------------------------------------------------------------
// peer_liveness_table_top
// Ordered table of peer addresses with liveness, counters and timeouts.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         tdata: mac, now_ms; tuser: cmd, parse_ok, is_heartbeat
//  m_axis    out        tdata: ok .. tx_packets; tuser: event_res; tlast: last
//  cfg       in         cfg_index_i selects register, cfg_data_i holds value
//
//  One command at a time. Address lookup walks the table, one entry a cycle;
//  a remove then shifts every entry after the hit one place down. A receive
//  that connects sends a second beat. A tick sweeps all entries once.
//  Result beats stall on m_axis_tready; a tick holds one result back so the
//  final beat carries tlast. Reset empties the table; no clearing pass.
// ----------------------------------------------------------------------------
module peer_liveness_table_top #(
  parameter int unsigned TABLE_SIZE = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [79:0]   s_axis_tdata,   // mac[47:0], now_ms[79:48]
  input  logic [4:0]    s_axis_tuser,   // cmd[2:0], parse_ok[3], is_heartbeat[4]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [119:0]  m_axis_tdata,   // ok[0], peer_mac[48:1], peer_is_connected[49],
                                        // any_connected[50], rx_packets[82:51],
                                        // tx_packets[114:83], zero[119:115]
  output logic [3:0]    m_axis_tuser,   // event_res[3:0]
  output logic          m_axis_tlast,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);
  import plt_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  res_t    res;

  assign cfg_ready_o = 1'b1;

  plt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser[2:0]),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  plt_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = res.ev;
  assign m_axis_tdata = {5'd0, res.tx, res.rx, res.any, res.pc, res.mac, res.ok};

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for peer_liveness_table_top: a directed command table,
// then random traffic over a small address pool, all checked beat by beat
// against an in-bench model of the peer table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import plt_pkg::*;

  localparam int unsigned TBL = 20;
  localparam int unsigned WD_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [47:0] mac;
    logic [31:0] now;
    logic        pok;
    logic        hb;
  } cmd_beat_t;

  typedef struct packed {
    logic [3:0]  ev;
    logic        ok;
    logic [47:0] mac;
    logic        pc;
    logic        any;
    logic [31:0] rx;
    logic [31:0] tx;
    logic        lst;
  } ev_beat_t;

  // directed row: command plus optional typed-in first result
  typedef struct {
    cmd_beat_t c;
    bit        fixed;
    logic [3:0] ev;
    logic       ok;
  } row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic [4:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [119:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  peer_liveness_table_top #(.TABLE_SIZE(TBL)) dut (.*);

  // model state
  logic [47:0] m_mac [TBL];
  bit          m_conn [TBL];
  logic [31:0] m_seen [TBL];
  logic [31:0] m_rx [TBL];
  logic [31:0] m_tx [TBL];
  int          m_cnt;
  logic [31:0] m_last_hb;
  logic [4:0]  r_max;
  logic [31:0] r_tmo, r_hbi;
  logic        r_hben;

  ev_beat_t expected_events[$];
  ev_beat_t first_pred;
  row_t rows[$];
  int   fails;
  bit   quiet_phase;
  int   idle_cycles;
  logic [47:0] mac_pool [8];

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit any_conn();
    for (int i = 0; i < m_cnt; i++) if (m_conn[i]) return 1;
    return 0;
  endfunction

  function automatic int find_peer(logic [47:0] mac);
    for (int i = 0; i < m_cnt; i++) if (m_mac[i] == mac) return i;
    return -1;
  endfunction

  task automatic push_event(logic [3:0] ev, logic ok, logic [47:0] mac,
                            logic pc, logic [31:0] rx, logic [31:0] tx);
    ev_beat_t e;
    e = '{ev, ok, mac, pc, any_conn(), rx, tx, 1'b0};
    expected_events.insert(expected_events.size(), e);
  endtask

  task automatic add_row(cmd_beat_t c, bit fixed, logic [3:0] ev, logic ok);
    row_t r;
    r.c = c; r.fixed = fixed; r.ev = ev; r.ok = ok;
    rows.insert(rows.size(), r);
  endtask

  task automatic predict_table(cmd_beat_t c);
    int idx, lim, n0;
    idx = find_peer(c.mac);
    n0 = expected_events.size();
    case (c.cmd)
      CMD_ADD: begin
        lim = (r_max == 0) ? 1 : (r_max > TBL ? TBL : r_max);
        if (idx >= 0) push_event(EV_ADDED, 1, c.mac, 0, 0, 0);
        else if (m_cnt >= lim) push_event(EV_ADD_REJ, 0, c.mac, 0, 0, 0);
        else begin
          m_mac[m_cnt] = c.mac; m_conn[m_cnt] = 0; m_seen[m_cnt] = 0;
          m_rx[m_cnt] = 0; m_tx[m_cnt] = 0; m_cnt++;
          push_event(EV_ADDED, 1, c.mac, 0, 0, 0);
        end
      end
      CMD_REMOVE: begin
        if (idx >= 0) begin
          for (int i = idx; i + 1 < m_cnt; i++) begin
            m_mac[i] = m_mac[i+1]; m_conn[i] = m_conn[i+1]; m_seen[i] = m_seen[i+1];
            m_rx[i] = m_rx[i+1]; m_tx[i] = m_tx[i+1];
          end
          m_cnt--; m_conn[m_cnt] = 0;
          push_event(EV_REMOVED, 1, c.mac, 0, 0, 0);
        end else push_event(EV_REM_MISS, 0, c.mac, 0, 0, 0);
      end
      CMD_CLEAR: begin
        for (int i = 0; i < TBL; i++) m_conn[i] = 0;
        m_cnt = 0;
        push_event(EV_ACK, 1, '0, 0, 0, 0);
      end
      CMD_RECEIVE: begin
        if (!c.pok) push_event(EV_BAD_PKT, 0, c.mac, 0, 0, 0);
        else begin
          if (idx >= 0) begin
            bit was_off;
            was_off = !m_conn[idx];
            m_conn[idx] = 1; m_seen[idx] = c.now; m_rx[idx] = m_rx[idx] + 1;
            if (was_off) push_event(EV_CONNECTED, 1, c.mac, 0, 0, 0);
          end
          push_event(c.hb ? EV_HB_RX : EV_DATA_RX, idx >= 0, c.mac, 0, 0, 0);
        end
      end
      CMD_SENT: begin
        if (idx >= 0) m_tx[idx] = m_tx[idx] + 1;
        push_event(EV_ACK, idx >= 0, c.mac, 0, 0, 0);
      end
      CMD_TICK: begin
        if (any_conn() && r_hben && (c.now - m_last_hb) >= r_hbi) begin
          for (int i = 0; i < m_cnt; i++) m_tx[i] = m_tx[i] + 1;
          m_last_hb = c.now;
          push_event(EV_HB_DUE, 1, '0, 0, 0, 0);
        end
        for (int i = 0; i < m_cnt; i++)
          if (m_conn[i] && m_seen[i] != 0 && (c.now - m_seen[i]) > r_tmo) begin
            m_conn[i] = 0;
            push_event(EV_TIMED_OUT, 1, m_mac[i], 0, 0, 0);
          end
        if (expected_events.size() == n0) push_event(EV_TICK_DONE, 1, '0, 0, 0, 0);
      end
      CMD_QUERY: begin
        if (idx >= 0) push_event(EV_ACK, 1, c.mac, m_conn[idx], m_rx[idx], m_tx[idx]);
        else push_event(EV_ACK, 0, c.mac, 0, 0, 0);
      end
      default: push_event(EV_ACK, 0, c.mac, 0, 0, 0);
    endcase
    expected_events[$].lst = 1;
    first_pred = expected_events[n0];
  endtask

  // result side: random stall, compare each beat with the oldest expectation
  initial begin
    ev_beat_t got, exp_b;
    m_axis_tready = 0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = quiet_phase ? 1'b1 : ($urandom_range(99) >= 14);
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        got = '{m_axis_tuser, m_axis_tdata[0], m_axis_tdata[48:1], m_axis_tdata[49],
                m_axis_tdata[50], m_axis_tdata[82:51], m_axis_tdata[114:83], m_axis_tlast};
        if (expected_events.size() == 0) begin
          fails++;
          $display("%0t unexpected beat: actual %p", $realtime, got);
        end else begin
          exp_b = expected_events.pop_front();
          if (got !== exp_b) begin
            fails++;
            $display("%0t mismatch: expected %p actual %p", $realtime, exp_b, got);
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("FAIL peer_liveness_table_top");
        $finish;
      end
    end
  end

  task automatic send_cmd(cmd_beat_t c);
    @(negedge clk_i);
    while (!quiet_phase && $urandom_range(99) < 14) @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {c.now, c.mac};
    s_axis_tuser <= {c.hb, c.pok, c.cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    idle_cycles = 0;
    predict_table(c);
    @(negedge clk_i);
    s_axis_tvalid <= 0;
  endtask

  task automatic drain_wait();
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MAX_PEERS: r_max = val[4:0];
      REG_TIMEOUT:   r_tmo = val;
      REG_HB_EN:     r_hben = val[0];
      REG_HB_INT:    r_hbi = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  function automatic cmd_beat_t mk(logic [2:0] cmd, logic [47:0] mac, logic [31:0] now,
                                   logic pok = 1, logic hb = 0);
    cmd_beat_t c;
    c = '{cmd, mac, now, pok, hb};
    return c;
  endfunction

  function automatic cmd_beat_t rand_cmd();
    cmd_beat_t c;
    int r;
    r = $urandom_range(99);
    c.mac = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                     : mac_pool[$urandom_range(7)];
    c.now = ($urandom_range(19) == 0) ? $urandom : $urandom_range(6000);
    c.pok = $urandom_range(9) != 0;
    c.hb = 1'($urandom_range(1));
    if (r < 20) c.cmd = CMD_ADD;
    else if (r < 28) c.cmd = CMD_REMOVE;
    else if (r < 30) c.cmd = CMD_CLEAR;
    else if (r < 55) c.cmd = CMD_RECEIVE;
    else if (r < 65) c.cmd = CMD_SENT;
    else if (r < 82) c.cmd = CMD_TICK;
    else if (r < 98) c.cmd = CMD_QUERY;
    else c.cmd = 3'd7;
    return c;
  endfunction

  initial begin
    cmd_beat_t c;
    fails = 0;
    quiet_phase = 0;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
    cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    m_cnt = 0; m_last_hb = 0;
    for (int i = 0; i < TBL; i++) m_conn[i] = 0;
    r_max = MAX_PEERS_RST; r_tmo = TIMEOUT_RST; r_hben = 0; r_hbi = HB_INT_RST;
    for (int i = 0; i < 8; i++) mac_pool[i] = 48'({$urandom, $urandom});
    mac_pool[0] = '0; mac_pool[1] = '1;
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;

    // directed table
    add_row(mk(CMD_TICK, 0, 0), 1, EV_TICK_DONE, 1);
    add_row(mk(CMD_QUERY, '1, 0), 1, EV_ACK, 0);
    add_row(mk(CMD_REMOVE, '1, 0), 1, EV_REM_MISS, 0);
    add_row(mk(CMD_ADD, '1, 0), 1, EV_ADDED, 1);
    add_row(mk(CMD_ADD, '1, 0), 1, EV_ADDED, 1);
    add_row(mk(CMD_ADD, 0, 0), 1, EV_ADDED, 1);
    add_row(mk(CMD_RECEIVE, '1, 0, 0), 1, EV_BAD_PKT, 0);
    add_row(mk(CMD_RECEIVE, '1, 100, 1, 1), 1, EV_CONNECTED, 1);
    add_row(mk(CMD_RECEIVE, '1, 200, 1, 0), 0, EV_ACK, 0);
    add_row(mk(CMD_RECEIVE, 48'h5, 200, 1, 1), 0, EV_ACK, 0);
    add_row(mk(CMD_RECEIVE, 0, 0, 1, 0), 0, EV_ACK, 0);
    add_row(mk(CMD_SENT, '1, 0), 0, EV_ACK, 0);
    add_row(mk(CMD_SENT, 48'h5, 0), 1, EV_ACK, 0);
    add_row(mk(CMD_QUERY, '1, 0), 0, EV_ACK, 0);
    add_row(mk(3'd7, 48'h5, 0), 1, EV_ACK, 0);
    add_row(mk(CMD_TICK, 48'hFFFFFFFF, 32'hFFFFFFFF), 0, EV_ACK, 0);
    add_row(mk(CMD_QUERY, 0, 0), 0, EV_ACK, 0);
    for (int i = 2; i < 7; i++) add_row(mk(CMD_ADD, 48'h100 + 48'(i), 0), 0, EV_ACK, 0);
    add_row(mk(CMD_REMOVE, 0, 0), 1, EV_REMOVED, 1);
    add_row(mk(CMD_CLEAR, 0, 0), 1, EV_ACK, 1);
    foreach (rows[i]) begin
      send_cmd(rows[i].c);
      if (rows[i].fixed && (first_pred.ev !== rows[i].ev ||
                            first_pred.ok !== rows[i].ok)) begin
        fails++;
        $display("%0t table row %0d: expected ev %0d ok %0d, model %0d %0d", $realtime, i,
                 rows[i].ev, rows[i].ok, first_pred.ev, first_pred.ok);
      end
    end
    drain_wait();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_MAX_PEERS, 0); write_reg(REG_HB_EN, 1);
                 write_reg(REG_HB_INT, 0); write_reg(REG_TIMEOUT, 0); end
        1: begin write_reg(REG_MAX_PEERS, 31); write_reg(REG_TIMEOUT, 1500);
                 write_reg(REG_HB_INT, 300); end
        2: begin write_reg(REG_MAX_PEERS, 20); write_reg(REG_TIMEOUT, 32'hFFFFFFFF);
                 write_reg(REG_HB_INT, 32'hFFFFFFFF); end
        3: begin write_reg(REG_MAX_PEERS, 3); write_reg(REG_HB_EN, 0);
                 write_reg(REG_TIMEOUT, 800); end
        4: begin write_reg(REG_MAX_PEERS, 1); write_reg(REG_HB_EN, 1);
                 write_reg(REG_HB_INT, 1000); end
        default: begin write_reg(REG_MAX_PEERS, 8); write_reg(REG_TIMEOUT, 2000); end
      endcase
      quiet_phase = (ph == 2);
      for (int k = 0; k < 80; k++) begin
        c = rand_cmd();
        send_cmd(c);
      end
      drain_wait();
    end
    quiet_phase = 0;

    if (fails == 0 && expected_events.size() == 0) begin
      $display("PASS peer_liveness_table_top");
    end else begin
      $display("FAIL peer_liveness_table_top");
    end
    $finish;
  end

endmodule
